@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the console line editor RTL.
// No dependencies; include where concurrent checks are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CLEB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cleb check failed");

// Next-cycle implication, disabled while reset is held.
`define CLEB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cleb check failed");

`endif

@@ rtl/core/cleb_pkg.sv @@
// Shared types, codes and helpers for the console line editor buffer.
// No dependencies; compile first after the assertion header.
package cleb_pkg;

    localparam int CLEB_LINE_DEPTH  = 64;
    localparam int CLEB_QUEUE_DEPTH = 2;
    localparam int CLEB_FILL_W      = 7;

    localparam logic [1:0] OP_KEY   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_BELL = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam logic [7:0] KEY_NUL    = 8'd0;
    localparam logic [7:0] KEY_BEL    = 8'd7;
    localparam logic [7:0] KEY_BS     = 8'd8;
    localparam logic [7:0] KEY_LF     = 8'd10;
    localparam logic [7:0] KEY_CR     = 8'd13;
    localparam logic [7:0] BELL_SOUND = 8'd4;

    typedef enum logic [2:0] {
        CMD_KEY_LF,
        CMD_KEY_BS,
        CMD_KEY_CHAR,
        CMD_READ,
        CMD_WRITE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
        logic [6:0] count;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [CLEB_FILL_W-1:0] fill;
        logic                   complete;
        logic                   reading;
    } t_back_status;

    typedef enum logic {
        BK_IDLE,
        BK_READ
    } t_back_state;

    // Console output path: LF goes out as CR, BEL becomes a sound.
    function automatic t_result console_out(logic [7:0] c);
        t_result r;
        r.last = 1'b1;
        if (c == KEY_BEL) begin
            r.kind = KIND_BELL;
            r.data = BELL_SOUND;
        end else if (c == KEY_LF) begin
            r.kind = KIND_CHAR;
            r.data = KEY_CR;
        end else begin
            r.kind = KIND_CHAR;
            r.data = c;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/cleb_if.sv @@
// Valid/ready channel interfaces for request and result streams.
// Depends on cleb_pkg for field widths.
interface cleb_in_if;
    import cleb_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] in_byte;
    logic [6:0] read_count;

    modport source (output valid, output operation, output in_byte, output read_count,
                    input ready);
    modport sink (input valid, input operation, input in_byte, input read_count,
                  output ready);
endinterface

interface cleb_out_if;
    import cleb_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_kind, output out_byte, output last,
                    input ready);
    modport sink (input valid, input out_kind, input out_byte, input last,
                  output ready);
endinterface

@@ rtl/core/cleb_front.sv @@
// Front end: accepts requests and classifies them into commands.
// Depends on cleb_pkg and cleb_in_if.
module cleb_front (
    cleb_in_if.sink         i_in,
    input  logic            i_push_ready,
    output logic            o_push_valid,
    output cleb_pkg::t_cmd  o_push_cmd
);
    import cleb_pkg::*;

    logic keep;

    assign i_in.ready = i_push_ready;

    always_comb begin
        keep             = 1'b1;
        o_push_cmd.data  = i_in.in_byte;
        o_push_cmd.count = i_in.read_count;
        o_push_cmd.kind  = CMD_WRITE;
        case (i_in.operation)
            OP_KEY: begin
                if (i_in.in_byte == KEY_NUL) begin
                    keep = 1'b0;
                end else if (i_in.in_byte == KEY_CR || i_in.in_byte == KEY_LF) begin
                    o_push_cmd.kind = CMD_KEY_LF;
                    o_push_cmd.data = KEY_LF;
                end else if (i_in.in_byte == KEY_BS) begin
                    o_push_cmd.kind = CMD_KEY_BS;
                end else begin
                    o_push_cmd.kind = CMD_KEY_CHAR;
                end
            end
            OP_READ:  o_push_cmd.kind = CMD_READ;
            OP_WRITE: o_push_cmd.kind = CMD_WRITE;
            default:  keep = 1'b0;  // drop unknown operation
        endcase
    end

    assign o_push_valid = i_in.valid && keep;

endmodule

@@ rtl/core/cleb_queue.sv @@
// Short command queue between front and back ends.
// Depends on cleb_pkg for the command type and depth.
module cleb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    input  cleb_pkg::t_cmd  i_push_cmd,
    output logic            o_push_ready,
    output logic            o_pop_valid,
    output cleb_pkg::t_cmd  o_pop_cmd,
    input  logic            i_pop
);
    import cleb_pkg::*;

    localparam int QW = $clog2(CLEB_QUEUE_DEPTH);
    localparam int CNTW = $clog2(CLEB_QUEUE_DEPTH + 1);

    t_cmd            r_slot [CLEB_QUEUE_DEPTH];
    logic [QW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNTW-1:0] r_count, n_count;
    logic            do_push, do_pop;

    assign o_push_ready = (r_count != CNTW'(CLEB_QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_slot[r_rd_ptr];
    assign do_push      = i_push_valid && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QW'(CLEB_QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QW'(CLEB_QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

@@ rtl/core/cleb_back.sv @@
// Back end: line store ring, editing state and result register.
// Depends on cleb_pkg and cleb_out_if.
module cleb_back #(
    parameter int LINE_DEPTH = cleb_pkg::CLEB_LINE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    input  cleb_pkg::t_cmd        i_cmd,
    output logic                  o_cmd_pop,
    output cleb_pkg::t_back_status o_status,
    cleb_out_if.source            o_out
);
    import cleb_pkg::*;

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int CW = $clog2(LINE_DEPTH + 1);

    logic [7:0]    r_mem [LINE_DEPTH];
    logic [7:0]    r_rdata;

    t_back_state   r_state, n_state;
    logic [CW-1:0] r_fill, n_fill;
    logic [AW-1:0] r_start, n_start;
    logic          r_complete, n_complete;
    logic [CW-1:0] r_left, n_left;
    logic          r_out_valid, n_out_valid;
    t_result       r_out, n_out;

    logic          out_free;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr, start_inc;
    logic [CW:0]   tail_sum;
    logic [CW-1:0] read_n;
    logic          read_empty;

    assign out_free  = !r_out_valid || o_out.ready;
    assign start_inc = (r_start == AW'(LINE_DEPTH - 1)) ? '0 : r_start + 1'b1;

    // Ring tail: start plus fill, wrapped once.
    always_comb begin
        tail_sum = (CW + 1)'(r_start) + (CW + 1)'(r_fill);
        if (tail_sum >= (CW + 1)'(LINE_DEPTH)) begin
            tail_sum = tail_sum - (CW + 1)'(LINE_DEPTH);
        end
        wr_addr = AW'(tail_sum);
    end

    assign read_empty = !r_complete || (i_cmd.count == '0) || (r_fill == '0);
    assign read_n     = (i_cmd.count < 7'(r_fill)) ? CW'(i_cmd.count) : r_fill;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid && out_free && i_cmd.kind == CMD_READ && !read_empty) begin
                    n_state = BK_READ;
                end
            end
            BK_READ: begin
                if (out_free && r_left == CW'(1)) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Actions
    always_comb begin
        o_cmd_pop   = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_start;
        n_fill      = r_fill;
        n_start     = r_start;
        n_complete  = r_complete;
        n_left      = r_left;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out       = r_out;
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.kind)
                        CMD_KEY_LF: begin
                            if (!r_complete) begin
                                wr_en       = 1'b1;
                                n_fill      = r_fill + 1'b1;
                                n_complete  = 1'b1;
                                n_out_valid = 1'b1;
                                n_out       = console_out(i_cmd.data);
                            end
                        end
                        CMD_KEY_BS: begin
                            if (!r_complete && r_fill != '0) begin
                                n_fill      = r_fill - 1'b1;
                                n_out_valid = 1'b1;
                                n_out       = console_out(i_cmd.data);
                            end
                        end
                        CMD_KEY_CHAR: begin
                            if (!r_complete) begin
                                n_out_valid = 1'b1;
                                // keep room for the closing newline
                                if ((CW + 1)'(r_fill) + 1'b1 < (CW + 1)'(LINE_DEPTH)) begin
                                    wr_en  = 1'b1;
                                    n_fill = r_fill + 1'b1;
                                    n_out  = console_out(i_cmd.data);
                                end else begin
                                    n_out  = console_out(KEY_BEL);
                                end
                            end
                        end
                        CMD_WRITE: begin
                            n_out_valid = 1'b1;
                            n_out       = console_out(i_cmd.data);
                        end
                        CMD_READ: begin
                            if (read_empty) begin
                                n_out_valid = 1'b1;
                                n_out.kind  = KIND_NONE;
                                n_out.data  = '0;
                                n_out.last  = 1'b1;
                            end else begin
                                rd_en  = 1'b1;
                                n_left = read_n;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BK_READ: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out.kind  = KIND_DATA;
                    n_out.data  = r_rdata;
                    n_out.last  = (r_left == CW'(1));
                    n_start     = start_inc;
                    n_fill      = r_fill - 1'b1;
                    n_left      = r_left - 1'b1;
                    if (r_left == CW'(1)) begin
                        if (r_fill == CW'(1)) begin
                            n_complete = 1'b0;
                        end
                    end else begin
                        // fetch the following byte
                        rd_en   = 1'b1;
                        rd_addr = start_inc;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_fill      <= '0;
            r_start     <= '0;
            r_complete  <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_start     <= n_start;
            r_complete  <= n_complete;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_cmd.data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_kind = r_out.kind;
    assign o_out.out_byte = r_out.data;
    assign o_out.last     = r_out.last;

    assign o_status.fill     = CLEB_FILL_W'(r_fill);
    assign o_status.complete = r_complete;
    assign o_status.reading  = (r_state == BK_READ);

endmodule

@@ rtl/core/console_line_editor_buffer.sv @@
// Top level of the console line editor buffer: front, queue and back end.
// Depends on cleb_pkg, cleb_if, cleb_front, cleb_queue, cleb_back.
//
//   channel  dir  handshake     payload
//   i_in     in   valid/ready   operation, in_byte, read_count
//   o_out    out  valid/ready   out_kind, out_byte, last
//
// A key or write request that gives a result leaves the back end in the cycle
// after it is popped from the two-entry queue; one request per cycle is
// sustained while the receiver is ready. A read fetches the first byte from
// the line store (one read port), then gives one byte per cycle while the
// receiver is ready, taking no new request until its last byte is out. Reset
// is synchronous and clears control state only, not the line store; requests
// are taken once it is released. A stalled result holds in the output
// register while the queue keeps taking requests until it is full.
`include "assert_macros.svh"

module console_line_editor_buffer #(
    parameter int LINE_DEPTH = cleb_pkg::CLEB_LINE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cleb_in_if.sink     i_in,
    cleb_out_if.source  o_out
);
    import cleb_pkg::*;

    logic         push_valid, push_ready;
    t_cmd         push_cmd;
    logic         pop_valid, pop;
    t_cmd         pop_cmd;
    t_back_status status;

    cleb_front u_front (
        .i_in         (i_in),
        .i_push_ready (push_ready),
        .o_push_valid (push_valid),
        .o_push_cmd   (push_cmd)
    );

    cleb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_cmd    (pop_cmd),
        .i_pop        (pop)
    );

    cleb_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (pop_valid),
        .i_cmd       (pop_cmd),
        .o_cmd_pop   (pop),
        .o_status    (status),
        .o_out       (o_out)
    );

    `CLEB_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, status.fill <= CLEB_FILL_W'(LINE_DEPTH))
    `CLEB_ASSERT_NOW(a_complete_nonempty, i_clk, i_rst_n, status.complete, status.fill != '0)
    `CLEB_ASSERT_NOW(a_full_is_line, i_clk, i_rst_n, status.fill == CLEB_FILL_W'(LINE_DEPTH), status.complete)
    `CLEB_ASSERT_NEXT(a_read_has_output, i_clk, i_rst_n, status.reading && o_out.ready, o_out.valid)

endmodule

@@ tb/sv/cleb_result_checker.sv @@
`timescale 1ns / 1ps
// Checker for the console line editor buffer: watches both channels, predicts
// the echo, bell and read results of every accepted request and compares them.
// Depends on cleb_pkg for codes and the result type.
module cleb_result_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_in_byte,
    input  logic [6:0] i_read_count,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [1:0] i_out_kind,
    input  logic [7:0] i_out_byte,
    input  logic       i_out_last,
    output int         o_fail_count,
    output int         o_pending
);
    import cleb_pkg::*;

    localparam int MAX_REPORTS = 10;

    logic [7:0] line_mem [CLEB_LINE_DEPTH];
    int         head;
    int         fill;
    logic       line_done;
    t_result    console_results [$];
    int         fails = 0;

    // LF goes to the console as CR, BEL as the bell sound.
    function automatic t_result echo_of(logic [7:0] c);
        t_result r;
        if (c == KEY_LF)
            c = KEY_CR;
        r.last = 1'b1;
        if (c == KEY_BEL) begin
            r.kind = KIND_BELL;
            r.data = BELL_SOUND;
        end else begin
            r.kind = KIND_CHAR;
            r.data = c;
        end
        return r;
    endfunction

    function void append_byte(logic [7:0] c);
        line_mem[(head + fill) % CLEB_LINE_DEPTH] = c;
        fill++;
    endfunction

    function void line_discipline_step(logic [1:0] op, logic [7:0] b, logic [6:0] cnt);
        int      want;
        int      n;
        int      k;
        t_result r;
        case (op)
            OP_KEY: begin
                // Drop keys while a finished line waits, and NUL always.
                if (!line_done && b != KEY_NUL) begin
                    if (b == KEY_CR)
                        b = KEY_LF;
                    if (b == KEY_LF) begin
                        append_byte(b);
                        line_done = 1'b1;
                        console_results.push_back(echo_of(b));
                    end else if (b == KEY_BS) begin
                        if (fill != 0) begin
                            fill--;
                            console_results.push_back(echo_of(b));
                        end
                    end else if (fill + 1 < CLEB_LINE_DEPTH) begin
                        append_byte(b);
                        console_results.push_back(echo_of(b));
                    end else begin
                        // Hold the last slot for the newline.
                        console_results.push_back(echo_of(KEY_BEL));
                    end
                end
            end
            OP_READ: begin
                want = (cnt > CLEB_LINE_DEPTH) ? CLEB_LINE_DEPTH : int'(cnt);
                if (!line_done || want == 0 || fill == 0) begin
                    r.kind = KIND_NONE;
                    r.data = 8'd0;
                    r.last = 1'b1;
                    console_results.push_back(r);
                end else begin
                    n = (want < fill) ? want : fill;
                    for (k = 0; k < n; k++) begin
                        r.kind = KIND_DATA;
                        r.data = line_mem[(head + k) % CLEB_LINE_DEPTH];
                        r.last = (k + 1 == n);
                        console_results.push_back(r);
                    end
                    head = (head + n) % CLEB_LINE_DEPTH;
                    fill = fill - n;
                    if (fill == 0)
                        line_done = 1'b0;
                end
            end
            OP_WRITE: begin
                console_results.push_back(echo_of(b));
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            head = 0;
            fill = 0;
            line_done = 1'b0;
            foreach (line_mem[i])
                line_mem[i] = 8'd0;
            console_results.delete();
        end else begin
            // Compare outputs before adding new predictions: a result never
            // leaves in the cycle its request is taken.
            if (i_out_valid && i_out_ready) begin
                if (console_results.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("unexpected result: kind %0d byte %02h last %0d",
                                 i_out_kind, i_out_byte, i_out_last);
                end else begin
                    want = console_results.pop_front();
                    if (want.kind != i_out_kind || want.data != i_out_byte ||
                        want.last != i_out_last) begin
                        fails++;
                        if (fails <= MAX_REPORTS) begin
                            $display("result mismatch: expected kind %0d byte %02h last %0d,",
                                     want.kind, want.data, want.last);
                            $display("  got kind %0d byte %02h last %0d",
                                     i_out_kind, i_out_byte, i_out_last);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                line_discipline_step(i_operation, i_in_byte, i_read_count);
        end
        o_fail_count <= fails;
        o_pending    <= console_results.size();
    end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the console line editor buffer testbench: clock, reset, request
// stimulus, receiver stalls, watchdog and verdict. Depends on cleb_pkg,
// cleb_if, the block and cleb_result_checker.
module tb_top;
    import cleb_pkg::*;

    localparam int          CLK_HALF       = 10;
    localparam int          RESET_CYCLES   = 8;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          TAIL_CYCLES    = 80;
    localparam logic [1:0]  OP_NONE        = 2'd3;

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   fail_count;
    int   pending;
    int   quiet_cycles;
    int   items_sent;

    cleb_in_if  in_if ();
    cleb_out_if out_if ();

    console_line_editor_buffer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    cleb_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_if.valid),
        .i_in_ready   (in_if.ready),
        .i_operation  (in_if.operation),
        .i_in_byte    (in_if.in_byte),
        .i_read_count (in_if.read_count),
        .i_out_valid  (out_if.valid),
        .i_out_ready  (out_if.ready),
        .i_out_kind   (out_if.out_kind),
        .i_out_byte   (out_if.out_byte),
        .i_out_last   (out_if.last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Receiver stalls at the rate of the current phase.
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    task automatic send_req(input logic [1:0] op, input logic [7:0] b, input logic [6:0] cnt);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.operation  <= op;
        in_if.in_byte    <= b;
        in_if.read_count <= cnt;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        if (op != OP_NONE && !(op == OP_KEY && b == KEY_NUL))
            items_sent++;
    endtask

    // Let the checker register its pending count first, so that it includes the last request.
    task automatic drain_results();
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [7:0] line_key();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 8'($urandom_range(32, 126));
        else if (r < 70)
            return KEY_BS;
        else if (r < 75)
            return KEY_BEL;
        else if (r < 80)
            return KEY_NUL;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] write_byte();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return KEY_LF;
        else if (r < 30)
            return KEY_BEL;
        return 8'($urandom_range(255));
    endfunction

    // Type a line, end it, then read it out. A plain line holds printable
    // keys and bells only, so that it runs into the full-line bell.
    task automatic send_line(input int n_keys, input bit plain);
        int          i;
        int          r;
        int          cnt;
        int          remaining;
        logic [7:0]  k;
        remaining = 1;
        for (i = 0; i < n_keys; i++) begin
            if (!plain) begin
                r = $urandom_range(99);
                if (r < 10)
                    send_req(OP_WRITE, write_byte(), 7'($urandom_range(127)));
                else if (r < 13)
                    send_req(OP_NONE, 8'($urandom_range(255)), 7'($urandom_range(127)));
                else if (r < 17)
                    send_req(OP_READ, 8'($urandom_range(255)), 7'($urandom_range(127)));
            end
            if (plain)
                k = ($urandom_range(9) == 0) ? KEY_BEL : 8'($urandom_range(32, 126));
            else
                k = line_key();
            send_req(OP_KEY, k, 7'($urandom_range(127)));
            remaining++;
        end
        send_req(OP_KEY, $urandom_range(1) ? KEY_CR : KEY_LF, 7'($urandom_range(127)));
        if ($urandom_range(99) < 30)
            send_req(OP_KEY, line_key(), 7'($urandom_range(127)));
        if (plain) begin
            send_req(OP_READ, 8'($urandom_range(255)), 7'($urandom_range(64, 127)));
        end else begin
            // Read in pieces until the stored bytes are surely gone.
            while (remaining > 0) begin
                r = $urandom_range(99);
                if (r < 10)
                    cnt = 0;
                else if (r < 20)
                    cnt = $urandom_range(64, 127);
                else
                    cnt = $urandom_range(1, 16);
                send_req(OP_READ, 8'($urandom_range(255)), cnt[6:0]);
                remaining -= cnt;
            end
        end
        if ($urandom_range(99) < 25)
            send_req(OP_READ, 8'($urandom_range(255)), 7'($urandom_range(127)));
    endtask

    initial begin : stimulus
        int phase;
        int line_no;
        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.operation  <= OP_KEY;
        in_if.in_byte    <= 8'd0;
        in_if.read_count <= 7'd0;
        items_sent    = 0;
        send_idle_pct = 13;
        recv_idle_pct = 74;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: console writes, ignored items, reads and two short lines.
        send_req(OP_READ, 8'd0, 7'd5);
        send_req(OP_WRITE, 8'h00, 7'd0);
        send_req(OP_WRITE, 8'hFF, 7'h7F);
        send_req(OP_WRITE, KEY_LF, 7'd0);
        send_req(OP_WRITE, KEY_BEL, 7'd0);
        send_req(OP_WRITE, KEY_CR, 7'd0);
        send_req(OP_NONE, 8'hFF, 7'h7F);
        send_req(OP_KEY, KEY_NUL, 7'd0);
        send_req(OP_KEY, KEY_BS, 7'd0);
        send_req(OP_KEY, 8'h41, 7'd0);
        send_req(OP_KEY, KEY_BEL, 7'd0);
        send_req(OP_KEY, 8'hFF, 7'd0);
        send_req(OP_KEY, KEY_BS, 7'd0);
        send_req(OP_KEY, KEY_CR, 7'd0);
        send_req(OP_KEY, 8'h78, 7'd0);
        send_req(OP_READ, 8'hFF, 7'd0);
        send_req(OP_READ, 8'd0, 7'd1);
        send_req(OP_READ, 8'd0, 7'h7F);
        send_req(OP_READ, 8'd0, 7'd1);
        send_req(OP_KEY, KEY_LF, 7'd0);
        send_req(OP_READ, 8'd0, 7'd64);

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 13;
                    recv_idle_pct = 74;
                end
                1: begin
                    send_idle_pct = 74;
                    recv_idle_pct = 13;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            line_no = 0;
            while (items_sent < 130 + 100 * phase) begin
                if (phase == 1 && line_no == 0)
                    send_line(66, 1'b1);
                else if ($urandom_range(19) == 0)
                    send_line($urandom_range(40, 70), 1'b0);
                else
                    send_line($urandom_range(0, 8), 1'b0);
                line_no++;
            end
            // Hold off the sender until every result of the phase is out.
            in_if.valid <= 1'b0;
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
